FILE: hw/rtl/tcfd_pkg.sv
// Package for the touch controller frame decoder.
// Types, codes and constants shared by the rtl files. No dependencies.
package tcfd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        RK_TOUCH   = 3'd0,
        RK_BAD     = 3'd1,
        RK_DONE    = 3'd2,
        RK_BOOT    = 3'd3,
        RK_INVALID = 3'd4,
        RK_UNKNOWN = 3'd5,
        RK_FRAME   = 3'd6
    } t_kind;

    localparam logic [7:0] START_BYTE = 8'hEE;
    localparam logic [7:0] ID_CMD0    = 8'h00;
    localparam logic [7:0] ID_CMD1    = 8'h01;
    localparam logic [7:0] ID_CMD2    = 8'h02;
    localparam logic [7:0] ID_CMD3    = 8'h03;
    localparam logic [7:0] ID_CMD8    = 8'h08;
    localparam logic [7:0] ID_TOUCH   = 8'h04;
    localparam logic [7:0] ID_BOOT    = 8'h07;
    localparam logic [7:0] ID_PULSE   = 8'h0F;
    localparam logic [7:0] ID_LEVEL   = 8'h1C;
    localparam logic [7:0] ID_STATUS  = 8'h1E;
    localparam logic [7:0] ID_INVALID = 8'hFE;
    localparam logic [9:0] PULSE_EXPECTED = 10'd54;
    localparam logic [10:0] PRESSURE_DOWN = 11'd1024;
    localparam logic [15:0] Y_SPAN_RESET = 16'd800;
    localparam logic [1:0] REG_Y_SPAN = 2'd0;

    // frame handed from front to back
    typedef struct packed {
        logic        frame_err;
        logic [7:0]  id;
        logic [47:0] data;
    } t_frame;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic        touch_down;
        logic [10:0] pressure;
        logic [3:0]  contact_id;
        logic [7:0]  done_cmd;
        logic [7:0]  done_code;
        logic        boot_flag;
        logic [31:0] error_total;
        logic [15:0] fw_major;
    } t_result;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] command_id;
    } t_req;

endpackage

FILE: hw/rtl/tcfd_if.sv
// Valid/ready channel interfaces for the frame decoder.
// Depends on tcfd_pkg.
interface tcfd_req_if;
    logic           valid;
    logic           ready;
    tcfd_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tcfd_res_if;
    logic              valid;
    logic              ready;
    tcfd_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/tcfd_front.sv
// Front end: byte framing and capture of id and data bytes.
// Depends on tcfd_pkg. Emits completed frames, framing errors and awaited command events.
module tcfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcfd_pkg::t_req    i_req,
    input  logic              i_take,
    output logic              o_push,
    output tcfd_pkg::t_frame  o_frame,
    output logic              o_cmd_push,
    output logic [7:0]        o_cmd
);
    tcfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_id, n_id;
    logic [47:0] r_data, n_data;
    logic [7:0]  b;
    logic [7:0]  left_dec;

    assign b = i_req.rx_byte;
    assign o_cmd_push = i_take && i_req.req_type;
    assign o_cmd = i_req.command_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tcfd_pkg::PH_HUNT;
            r_left  <= 8'd0;
            r_idx   <= 8'd0;
            r_id    <= 8'd0;
            r_data  <= 48'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_id    <= n_id;
            r_data  <= n_data;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_idx   = r_idx;
        n_id    = r_id;
        n_data  = r_data;
        o_push  = 1'b0;
        o_frame = '{frame_err: 1'b1, id: r_id, data: r_data};
        left_dec = (r_left != 8'd0) ? r_left - 8'd1 : 8'd0;
        if (i_take && !i_req.req_type) begin
            case (r_phase)
                tcfd_pkg::PH_LEN: begin
                    if (b == 8'd0) begin
                        n_phase = tcfd_pkg::PH_HUNT;
                        o_push = 1'b1;
                    end else begin
                        n_left  = b;
                        n_idx   = 8'd0;
                        n_id    = 8'd0;
                        n_data  = 48'd0;
                        n_phase = tcfd_pkg::PH_BODY;
                    end
                end
                tcfd_pkg::PH_BODY: begin
                    if (r_idx == 8'd0) n_id = b;
                    else if (r_idx <= 8'd6) n_data[(r_idx - 8'd1) * 8 +: 8] = b;
                    if (r_idx != 8'd255) n_idx = r_idx + 8'd1;
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase = tcfd_pkg::PH_HUNT;
                        o_push = 1'b1;
                        o_frame = '{frame_err: 1'b0, id: n_id, data: n_data};
                    end
                end
                default: begin
                    if (b == tcfd_pkg::START_BYTE) n_phase = tcfd_pkg::PH_LEN;
                    else begin
                        n_phase = tcfd_pkg::PH_HUNT;
                        o_push = 1'b1;
                    end
                end
            endcase
        end
    end
endmodule

FILE: hw/rtl/tcfd_back.sv
// Back end: frame decode, persistent state and output register.
// Depends on tcfd_pkg. Fed by a two-entry queue of frames and command events.
module tcfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_is_cmd,
    input  logic [7:0]        i_cmd,
    input  tcfd_pkg::t_frame  i_frame,
    output logic              o_pop,
    input  logic [15:0]       i_y_span,
    output logic              o_valid,
    input  logic              i_ready,
    output tcfd_pkg::t_result o_res
);
    logic [7:0]  r_await;
    logic [15:0] r_fw;
    logic [31:0] r_err;
    logic        r_boot;
    logic        r_valid;
    tcfd_pkg::t_result r_res;

    logic [7:0]  n_await;
    logic [15:0] n_fw;
    logic [31:0] n_err;
    logic        n_boot;
    logic        emit;
    tcfd_pkg::t_result res;
    logic [7:0]  d0, d1, d2, d3, d4, d5, id;
    logic [15:0] y;
    logic [1:0]  st;
    logic [9:0]  n_pulse;
    logic        space;

    assign space = !r_valid || i_ready;
    assign o_pop = i_valid && space;
    assign o_valid = r_valid;
    assign o_res = r_res;

    always_comb begin
        {d5, d4, d3, d2, d1, d0} = i_frame.data;
        id = i_frame.id;
        n_await = r_await;
        n_fw = r_fw;
        n_err = r_err;
        n_boot = r_boot;
        emit = 1'b0;
        res = '0;
        y = {d4, d3};
        st = 2'd0;
        n_pulse = {2'b0, d0} + {2'b0, d1} + 10'd2;
        if (i_is_cmd) begin
            n_await = i_cmd;
        end else if (i_frame.frame_err) begin
            emit = 1'b1;
            res.result_kind = tcfd_pkg::RK_FRAME;
        end else begin
            case (id)
                tcfd_pkg::ID_TOUCH: begin
                    emit = 1'b1;
                    if (r_fw == 16'd1) begin
                        st = d5[1:0];
                        res.contact_id = 4'd1;
                        y = i_y_span - y;
                    end else begin
                        st = d5[7:6];
                        res.contact_id = d5[5:2];
                    end
                    res.result_kind = (st == 2'd3) ? tcfd_pkg::RK_BAD : tcfd_pkg::RK_TOUCH;
                    res.x_pos = {d2, d1};
                    res.y_pos = y;
                    if (!st[1]) begin
                        res.touch_down = 1'b1;
                        res.pressure = tcfd_pkg::PRESSURE_DOWN;
                    end
                end
                tcfd_pkg::ID_BOOT: begin
                    emit = 1'b1;
                    n_boot = d0 != 8'd0;
                    res.result_kind = tcfd_pkg::RK_BOOT;
                    res.boot_flag = n_boot;
                end
                tcfd_pkg::ID_CMD0, tcfd_pkg::ID_CMD1, tcfd_pkg::ID_CMD2,
                tcfd_pkg::ID_CMD3, tcfd_pkg::ID_CMD8: begin
                    emit = id == r_await;
                    res.done_code = d0;
                end
                tcfd_pkg::ID_LEVEL: emit = id == r_await;
                tcfd_pkg::ID_PULSE: begin
                    emit = id == r_await;
                    if (n_pulse > tcfd_pkg::PULSE_EXPECTED) n_err = r_err + 32'd2;
                    else if (n_pulse != tcfd_pkg::PULSE_EXPECTED) n_err = r_err + 32'd1;
                end
                tcfd_pkg::ID_STATUS: begin
                    emit = id == r_await;
                    n_fw = {d1, d0};
                end
                tcfd_pkg::ID_INVALID: begin
                    emit = 1'b1;
                    n_err = r_err + 32'd1;
                    res.result_kind = tcfd_pkg::RK_INVALID;
                end
                default: begin
                    emit = 1'b1;
                    n_err = r_err + 32'd1;
                    res.result_kind = tcfd_pkg::RK_UNKNOWN;
                end
            endcase
            if (res.result_kind == tcfd_pkg::RK_TOUCH && id != tcfd_pkg::ID_TOUCH) begin
                res.result_kind = tcfd_pkg::RK_DONE;
                res.done_cmd = id;
            end
        end
        res.error_total = n_err;
        res.fw_major = n_fw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 8'd0;
            r_fw    <= 16'd0;
            r_err   <= 32'd0;
            r_boot  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_await <= n_await;
                r_fw    <= n_fw;
                r_err   <= n_err;
                r_boot  <= n_boot;
            end
            if (o_pop) r_valid <= emit;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= res;
    end
endmodule

FILE: hw/rtl/tcfd_queue.sv
// Two-entry queue between front and back ends.
// Depends on tcfd_pkg. Carries frames and awaited-command events.
module tcfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_is_cmd,
    input  logic [7:0]       i_cmd,
    input  tcfd_pkg::t_frame i_frame,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_is_cmd,
    output logic [7:0]       o_cmd,
    output tcfd_pkg::t_frame o_frame,
    output logic             o_has_room
);
    logic             r_cmd_q [2];
    logic [7:0]       r_c_q [2];
    tcfd_pkg::t_frame r_f_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_has_room = r_cnt != 2'd2;
    assign o_is_cmd = r_cmd_q[r_rp];
    assign o_cmd = r_c_q[r_rp];
    assign o_frame = r_f_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd_q[r_wp] <= i_is_cmd;
            r_c_q[r_wp] <= i_cmd;
            r_f_q[r_wp] <= i_frame;
        end
    end
endmodule

FILE: hw/rtl/touch_controller_frame_decoder_unit.sv
// Top level of the touch controller frame decoder.
// Depends on tcfd_pkg, tcfd_if, tcfd_front, tcfd_queue, tcfd_back.
//
// Usage:
// i_req (sink) takes one word per cycle: a received link byte or an
// awaited command id. o_res (source) gives at most one result word per
// frame end, frame error, or nothing for commands and unmatched completions.
// APB port: register 0 at byte address 0 holds legacy_y_span (reset 800).
// Input words are taken one per cycle while the queue has room. The
// closing byte's result passes the queue, then the output register.
// A two-entry queue parts the byte framer from the decoder; when the
// receiver stalls, the output register holds, the queue fills and
// i_req.ready falls once it is full. Reset (synchronous, active low)
// restarts hunting for the start byte and clears counters, awaited
// command and firmware version.
module touch_controller_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcfd_req_if.sink    i_req,
    tcfd_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_y_span;
    logic             take, push, cmd_push, room, q_valid, q_cmd, pop;
    logic [7:0]       cmd, q_c;
    tcfd_pkg::t_frame frame, q_f;

    assign pready = 1'b1;
    assign prdata = (paddr == tcfd_pkg::REG_Y_SPAN) ? {16'd0, r_y_span} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_y_span <= tcfd_pkg::Y_SPAN_RESET;
        else if (psel && penable && pwrite && paddr == tcfd_pkg::REG_Y_SPAN)
            r_y_span <= pwdata[15:0];
    end

    assign i_req.ready = room;
    assign take = i_req.valid && room;

    tcfd_front u_front (
        .i_clk, .i_rst_n,
        .i_req(i_req.payload), .i_take(take),
        .o_push(push), .o_frame(frame), .o_cmd_push(cmd_push), .o_cmd(cmd)
    );

    tcfd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push || cmd_push), .i_is_cmd(cmd_push), .i_cmd(cmd),
        .i_frame(frame), .i_pop(pop), .o_valid(q_valid), .o_is_cmd(q_cmd),
        .o_cmd(q_c), .o_frame(q_f), .o_has_room(room)
    );

    tcfd_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_is_cmd(q_cmd), .i_cmd(q_c), .i_frame(q_f),
        .o_pop(pop), .i_y_span(r_y_span),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(o_res.payload)
    );
endmodule

FILE: hw/rtl/tcfd_checker.sv
// Port-level checks for the frame decoder.
// Depends on tcfd_pkg; bound to touch_controller_frame_decoder_unit.
module tcfd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input tcfd_pkg::t_result out_res,
    input logic              pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("result dropped under stall");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_res.result_kind <= tcfd_pkg::RK_FRAME)
        else $error("bad kind");
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_res.touch_down == (out_res.pressure != 11'd0)))
        else $error("pressure mismatch");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind touch_controller_frame_decoder_unit tcfd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(o_res.valid),
    .out_ready(o_res.ready), .out_res(o_res.payload), .pready(pready)
);

FILE: test/tb_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the touch controller frame decoder: predicts each result word
// from the accepted request words and APB writes, and compares what comes out.
// Depends on tcfd_pkg and tcfd_if.
module tb_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcfd_req_if         req,
    tcfd_res_if         res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int BODY_DATA = 6;

    tcfd_pkg::t_result expected_results[$];
    logic [15:0]       y_span;
    tcfd_pkg::t_phase  phase;
    logic [7:0]        bytes_left;
    logic [7:0]        body_idx;
    logic [7:0]        resp_id;
    logic [7:0]        body_data[BODY_DATA];
    logic [7:0]        awaited;
    logic [15:0]       fw_ver;
    logic [31:0]       err_count;
    logic              boot_state;

    assign o_pending = expected_results.size();

    initial o_fail_count = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic tcfd_pkg::t_result base_result(tcfd_pkg::t_kind kind);
        tcfd_pkg::t_result r;
        r = '0;
        r.result_kind = kind;
        r.error_total = err_count;
        r.fw_major = fw_ver;
        return r;
    endfunction

    task automatic complete_if_awaited(logic [7:0] code);
        tcfd_pkg::t_result r;
        if (resp_id == awaited) begin
            r = base_result(tcfd_pkg::RK_DONE);
            r.done_cmd = resp_id;
            r.done_code = code;
            expected_results.push_back(r);
        end
    endtask

    task automatic decode_frame();
        tcfd_pkg::t_result r;
        logic [15:0]       y;
        logic [1:0]        st;
        logic [3:0]        cid;
        logic [9:0]        pulse_sum;
        case (resp_id)
            tcfd_pkg::ID_TOUCH: begin
                y = {body_data[4], body_data[3]};
                if (fw_ver == 16'd1) begin
                    st = body_data[5][1:0];
                    cid = 4'd1;
                    y = y_span - y;
                end else begin
                    st = body_data[5][7:6];
                    cid = body_data[5][5:2];
                end
                r = base_result(st == 2'd3 ? tcfd_pkg::RK_BAD : tcfd_pkg::RK_TOUCH);
                r.x_pos = {body_data[2], body_data[1]};
                r.y_pos = y;
                r.contact_id = cid;
                if (st < 2'd2) begin
                    r.touch_down = 1'b1;
                    r.pressure = tcfd_pkg::PRESSURE_DOWN;
                end
                expected_results.push_back(r);
            end
            tcfd_pkg::ID_BOOT: begin
                boot_state = body_data[0] != 8'd0;
                r = base_result(tcfd_pkg::RK_BOOT);
                r.boot_flag = boot_state;
                expected_results.push_back(r);
            end
            tcfd_pkg::ID_CMD0, tcfd_pkg::ID_CMD1, tcfd_pkg::ID_CMD2,
            tcfd_pkg::ID_CMD3, tcfd_pkg::ID_CMD8: complete_if_awaited(body_data[0]);
            tcfd_pkg::ID_LEVEL: complete_if_awaited(8'd0);
            tcfd_pkg::ID_PULSE: begin
                pulse_sum = body_data[0] + body_data[1] + 10'd2;
                if (pulse_sum != tcfd_pkg::PULSE_EXPECTED) err_count++;
                if (pulse_sum > tcfd_pkg::PULSE_EXPECTED) err_count++;
                complete_if_awaited(8'd0);
            end
            tcfd_pkg::ID_STATUS: begin
                fw_ver = {body_data[1], body_data[0]};
                complete_if_awaited(8'd0);
            end
            tcfd_pkg::ID_INVALID: begin
                err_count++;
                expected_results.push_back(base_result(tcfd_pkg::RK_INVALID));
            end
            default: begin
                err_count++;
                expected_results.push_back(base_result(tcfd_pkg::RK_UNKNOWN));
            end
        endcase
    endtask

    task automatic take_word(tcfd_pkg::t_req w);
        logic [7:0] b;
        b = w.rx_byte;
        if (w.req_type) begin
            awaited = w.command_id;
        end else if (phase == tcfd_pkg::PH_LEN) begin
            if (b == 8'd0) begin
                phase = tcfd_pkg::PH_HUNT;
                expected_results.push_back(base_result(tcfd_pkg::RK_FRAME));
            end else begin
                bytes_left = b;
                body_idx = 8'd0;
                resp_id = 8'd0;
                foreach (body_data[i]) body_data[i] = 8'd0;
                phase = tcfd_pkg::PH_BODY;
            end
        end else if (phase == tcfd_pkg::PH_BODY) begin
            if (body_idx == 8'd0) resp_id = b;
            else if (body_idx <= BODY_DATA) body_data[body_idx - 1] = b;
            if (body_idx < 8'd255) body_idx++;
            if (bytes_left > 8'd0) bytes_left--;
            if (bytes_left == 8'd0) begin
                phase = tcfd_pkg::PH_HUNT;
                decode_frame();
            end
        end else if (b == tcfd_pkg::START_BYTE) begin
            phase = tcfd_pkg::PH_LEN;
        end else begin
            expected_results.push_back(base_result(tcfd_pkg::RK_FRAME));
        end
    endtask

    task automatic check_result(tcfd_pkg::t_result got);
        tcfd_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report("unexpected result word, kind", got.result_kind, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind)
            report("result_kind", got.result_kind, want.result_kind);
        if (got.x_pos !== want.x_pos) report("x_pos", got.x_pos, want.x_pos);
        if (got.y_pos !== want.y_pos) report("y_pos", got.y_pos, want.y_pos);
        if (got.touch_down !== want.touch_down)
            report("touch_down", got.touch_down, want.touch_down);
        if (got.pressure !== want.pressure)
            report("pressure", got.pressure, want.pressure);
        if (got.contact_id !== want.contact_id)
            report("contact_id", got.contact_id, want.contact_id);
        if (got.done_cmd !== want.done_cmd)
            report("done_cmd", got.done_cmd, want.done_cmd);
        if (got.done_code !== want.done_code)
            report("done_code", got.done_code, want.done_code);
        if (got.boot_flag !== want.boot_flag)
            report("boot_flag", got.boot_flag, want.boot_flag);
        if (got.error_total !== want.error_total)
            report("error_total", got.error_total, want.error_total);
        if (got.fw_major !== want.fw_major)
            report("fw_major", got.fw_major, want.fw_major);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            y_span = tcfd_pkg::Y_SPAN_RESET;
            phase = tcfd_pkg::PH_HUNT;
            bytes_left = 8'd0;
            body_idx = 8'd0;
            resp_id = 8'd0;
            foreach (body_data[i]) body_data[i] = 8'd0;
            awaited = 8'd0;
            fw_ver = 16'd0;
            err_count = 32'd0;
            boot_state = 1'b0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == tcfd_pkg::REG_Y_SPAN)
                y_span = pwdata[15:0];
            if (res.valid && res.ready) check_result(res.payload);
            if (req.valid && req.ready) take_word(req.payload);
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the touch controller frame decoder: drives directed and
// random link bytes, command words and APB writes with random idling.
// Depends on tcfd_pkg, tcfd_if, the decoder rtl and tb_frame_checker.
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_IDS = 12;
    localparam logic [7:0] KNOWN_IDS[N_IDS] = '{tcfd_pkg::ID_CMD0, tcfd_pkg::ID_CMD1,
        tcfd_pkg::ID_CMD2, tcfd_pkg::ID_CMD3, tcfd_pkg::ID_CMD8, tcfd_pkg::ID_TOUCH,
        tcfd_pkg::ID_BOOT, tcfd_pkg::ID_PULSE, tcfd_pkg::ID_LEVEL, tcfd_pkg::ID_STATUS,
        tcfd_pkg::ID_INVALID, 8'h55};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = tcfd_pkg::REG_Y_SPAN;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;

    tcfd_req_if req ();
    tcfd_res_if res ();

    initial begin
        req.valid = 1'b0;
        req.payload = '0;
        res.ready = 1'b0;
    end

    touch_controller_frame_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .res          (res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[touch_controller_frame_decoder_unit] ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
            stall_left = idle_len();
        end
    end

    // ready only moves at the rising edge, so it is read at the falling edge
    task automatic put_word(logic kind, logic [7:0] b, logic [7:0] cmd);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.payload = '{req_type: kind, rx_byte: b, command_id: cmd};
        while (!req.ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic link_byte(logic [7:0] b);
        put_word(1'b0, b, 8'($urandom));
    endtask

    task automatic await_cmd(logic [7:0] cmd);
        put_word(1'b1, 8'($urandom), cmd);
    endtask

    // start byte, length, id, then data bytes; body beyond d is random
    task automatic send_frame(logic [7:0] len, logic [7:0] id, logic [7:0] d[6]);
        link_byte(tcfd_pkg::START_BYTE);
        link_byte(len);
        for (int i = 0; i < len; i++) begin
            if (i == 0) link_byte(id);
            else if (i <= 6) link_byte(d[i - 1]);
            else link_byte(8'($urandom));
        end
    endtask

    task automatic drain();
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_span(logic [15:0] value);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = tcfd_pkg::REG_Y_SPAN;
        pwdata = {16'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_traffic(int n_words);
        logic [7:0] d[6];
        logic [7:0] id;
        logic [7:0] len;
        int         sent;
        int         r;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 9) == 0);
            foreach (d[i]) d[i] = 8'($urandom);
            id = KNOWN_IDS[$urandom_range(0, N_IDS - 1)];
            if ($urandom_range(0, 9) == 0) id = 8'($urandom);
            if (id == tcfd_pkg::ID_TOUCH && $urandom_range(0, 3) == 0)
                d[5][1:0] = 2'($urandom);
            if (id == tcfd_pkg::ID_PULSE && $urandom_range(0, 1) == 0) begin
                d[0] = 8'($urandom_range(0, 52));
                d[1] = 8'd52 - d[0] + 8'($urandom_range(0, 2)) - 8'd1;
            end
            if (id == tcfd_pkg::ID_STATUS && $urandom_range(0, 1) == 0) begin
                d[0] = 8'($urandom_range(0, 2));
                d[1] = 8'd0;
            end
            len = 8'($urandom_range(1, 9));
            if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(10, 255));
            if (r < 8) begin
                link_byte(8'($urandom));
                sent += 1;
            end else if (r < 12) begin
                link_byte(tcfd_pkg::START_BYTE);
                link_byte(8'd0);
                sent += 2;
            end else if (r < 20) begin
                await_cmd(8'($urandom));
                sent += 1;
            end else begin
                if ($urandom_range(0, 1) == 0) await_cmd(id);
                send_frame(len, id, d);
                sent += len + 3;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic [7:0] d[6];
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // junk while hunting, zero length, short body
        link_byte(8'h00);
        link_byte(8'hFF);
        link_byte(tcfd_pkg::START_BYTE);
        link_byte(8'd0);
        d = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(8'd1, tcfd_pkg::ID_TOUCH, d);
        // legacy firmware, status completion, then flipped touch
        await_cmd(tcfd_pkg::ID_STATUS);
        d = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(8'd3, tcfd_pkg::ID_STATUS, d);
        d = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03};
        send_frame(8'd8, tcfd_pkg::ID_TOUCH, d);
        d = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(8'd3, tcfd_pkg::ID_STATUS, d);
        send_frame(8'd2, tcfd_pkg::ID_INVALID, d);

        write_span(16'hFFFF);
        random_traffic(220);
        write_span(16'h0000);
        random_traffic(220);
        drain();
        write_span(16'($urandom));
        random_traffic(260);
        drain();

        if (fail_count == 0) begin
            $display("[touch_controller_frame_decoder_unit] OK");
        end else begin
            $display("[touch_controller_frame_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule
